// ----- hdl/eds_pkg.sv -----
`default_nettype none
package eds_pkg;

  typedef enum logic [1:0] {
    ACT_COMPUTE = 2'd0,
    ACT_WR_INT  = 2'd1,
    ACT_WR_MID  = 2'd2,
    ACT_WR_LOW  = 2'd3
  } act_t;

  localparam logic [63:0] HALF_ROUND = 64'h80;
  localparam int unsigned INT_DEPTH  = 128;

  typedef struct packed {
    logic        comp;
    logic        trunc;
    logic        neg;
    logic        bypass;
    logic        zero;
    logic        k0nz;
    logic        k1nz;
    logic        k2nz;
    logic [5:0]  lz;
    logic [63:0] xin;
  } ctl_t;

  typedef struct packed {
    logic [6:0]  shift;
    logic [63:0] mant;
  } int_ent_t;

  // Leading-zero count; an all-zero word yields 63, and such operands take the bypass path.
  function automatic logic [5:0] lzc64(input logic [63:0] v);
    logic [5:0] n;
    logic       found;
    n     = 6'd63;
    found = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 6'(63 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/exp_decay_scaler.sv -----
`default_nettype none
// Scales a 64-bit operand by exp(-decay/65536) through a 15-stage pipeline that takes one
// transaction per clock while m_tready or an empty output stage lets it advance; the three
// chained 64x64 multiplies are each split over a partial-product stage and a summing
// stage. Table entries are loaded through the same stream (tuser action 1..3) and
// take effect for every compute transaction accepted after them; each load also returns a
// zero result. Entries must be written before a compute that uses them.
module exp_decay_scaler
  import eds_pkg::*;
#(
  parameter int unsigned MAX_EXPONENT = 127
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // tdata: table_index[7:0], table_word[71:8], table_shift[78:72], x_value[142:79],
  //        decay[174:143], truncate[175]
  input  wire logic [175:0] s_tdata,
  // tuser: action[1:0], signed_mode[2]
  input  wire logic [2:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // tdata: product[63:0]
  output logic [63:0]       m_tdata
);

  localparam int unsigned NST = 15;

  logic [7:0]  table_index;
  logic [63:0] table_word;
  logic [6:0]  table_shift;
  logic [63:0] x_value;
  logic [31:0] decay;
  logic        truncate;
  act_t        action;
  logic        signed_mode;

  assign table_index = s_tdata[7:0];
  assign table_word  = s_tdata[71:8];
  assign table_shift = s_tdata[78:72];
  assign x_value     = s_tdata[142:79];
  assign decay       = s_tdata[174:143];
  assign truncate    = s_tdata[175];
  assign action      = act_t'(s_tuser[1:0]);
  assign signed_mode = s_tuser[2];

  logic adv;
  logic acc;
  logic [NST:1] v;

  assign adv      = !v[NST] || m_tready;
  assign acc      = s_tvalid && adv;
  assign s_tready = adv;
  assign m_tvalid = v[NST];

  int_ent_t    int_mem [INT_DEPTH];
  logic [63:0] mid_mem [256];
  logic [63:0] low_mem [256];

  always_ff @(posedge clk) begin
    if (acc) begin
      unique case (action)
        ACT_WR_INT: begin
          if (!table_index[7]) begin
            int_mem[table_index[6:0]] <= '{shift: table_shift, mant: table_word};
          end
        end
        ACT_WR_MID: mid_mem[table_index] <= table_word;
        ACT_WR_LOW: low_mem[table_index] <= table_word;
        default: ;
      endcase
    end
  end

  ctl_t        c     [1:NST-1];
  logic [63:0] w     [1:12];
  logic [63:0] low_d [1:3];
  logic [63:0] mid_d [1:7];
  int_ent_t    int_d [1:10];
  logic [63:0] pp    [0:3];
  logic [63:0] hi, lo;
  logic [63:0] t6;
  logic [7:0]  n11, n12;
  logic [127:0] prod12;
  logic [63:0] v13, xs13, r14;

  logic [15:0] k0;
  ctl_t        c_in;
  ctl_t        c2_in;

  assign k0 = decay[31:16];

  always_comb begin
    c_in.comp   = (action == ACT_COMPUTE);
    c_in.trunc  = truncate;
    c_in.neg    = signed_mode && x_value[63];
    c_in.bypass = (decay == 32'd0) || (x_value == 64'd0);
    c_in.zero   = (k0 > 16'(MAX_EXPONENT)) || (k0 >= 16'(INT_DEPTH));
    c_in.k0nz   = (k0 != 16'd0);
    c_in.k1nz   = (decay[15:8] != 8'd0);
    c_in.k2nz   = (decay[7:0] != 8'd0);
    c_in.lz     = '0;
    c_in.xin    = x_value;
  end

  always_comb begin
    c2_in    = c[1];
    c2_in.lz = lzc64(w[1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NST-1:1], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage 1: capture, magnitude, table reads.
      c[1]     <= c_in;
      w[1]     <= c_in.neg ? 64'd0 - x_value : x_value;
      low_d[1] <= low_mem[decay[7:0]];
      mid_d[1] <= mid_mem[decay[15:8]];
      int_d[1] <= int_mem[decay[22:16]];

      // Stage 2: leading-zero count.
      c[2]    <= c2_in;
      w[2]    <= w[1];

      for (int i = 3; i <= NST - 1; i++) c[i] <= c[i-1];
      for (int i = 2; i <= 3; i++)  low_d[i] <= low_d[i-1];
      for (int i = 2; i <= 7; i++)  mid_d[i] <= mid_d[i-1];
      for (int i = 2; i <= 10; i++) int_d[i] <= int_d[i-1];

      // Stage 3: normalize.
      w[3] <= w[2] << c[2].lz;

      // Stages 4..7: subtract the low-byte term.
      w[4]  <= w[3];
      pp[0] <= w[3][31:0]  * low_d[3][31:0];
      pp[1] <= w[3][31:0]  * low_d[3][63:32];
      pp[2] <= w[3][63:32] * low_d[3][31:0];
      pp[3] <= w[3][63:32] * low_d[3][63:32];
      w[5]  <= w[4];
      {hi, lo} <= {64'd0, pp[0]} + {32'd0, pp[1], 32'd0} + {32'd0, pp[2], 32'd0}
                + {pp[3], 64'd0};
      w[6]  <= w[5];
      t6    <= hi + {63'd0, lo[63]} + HALF_ROUND;
      w[7]  <= c[6].k2nz ? w[6] - {8'd0, t6[63:8]} : w[6];
    end
  end

  // Second and third products each have their own bank of partial-product registers.
  logic [63:0] qb [0:3];
  logic [63:0] qc [0:3];
  logic [63:0] hb, lb;

  always_ff @(posedge clk) begin
    if (adv) begin
      // Stages 8..10: subtract the middle-byte term.
      w[8]  <= w[7];
      qb[0] <= w[7][31:0]  * mid_d[7][31:0];
      qb[1] <= w[7][31:0]  * mid_d[7][63:32];
      qb[2] <= w[7][63:32] * mid_d[7][31:0];
      qb[3] <= w[7][63:32] * mid_d[7][63:32];
      w[9]  <= w[8];
      {hb, lb} <= {64'd0, qb[0]} + {32'd0, qb[1], 32'd0} + {32'd0, qb[2], 32'd0}
                + {qb[3], 64'd0};
      w[10] <= c[9].k1nz ? w[9] - hb - {63'd0, lb[63]} : w[9];

      // Stages 11..12: integer-part product.
      w[11] <= w[10];
      qc[0] <= w[10][31:0]  * int_d[10].mant[31:0];
      qc[1] <= w[10][31:0]  * int_d[10].mant[63:32];
      qc[2] <= w[10][63:32] * int_d[10].mant[31:0];
      qc[3] <= w[10][63:32] * int_d[10].mant[63:32];
      n11   <= {1'b0, int_d[10].shift} + {2'd0, c[10].lz} + {7'd0, c[10].trunc};
      w[12] <= w[11];
      n12   <= n11;
      prod12 <= {64'd0, qc[0]} + {32'd0, qc[1], 32'd0} + {32'd0, qc[2], 32'd0}
              + {qc[3], 64'd0};

      // Stage 13: final shifts for both paths.
      v13 <= n12[7] ? 64'd0 : 64'(prod12 >> n12[6:0]);
      if (c[12].trunc || c[12].lz == 6'd0) begin
        xs13 <= w[12] >> c[12].lz;
      end else begin
        xs13 <= w[12] >> (c[12].lz - 6'd1);
      end

      // Stage 14: rounding.
      if (c[13].k0nz) begin
        r14 <= c[13].trunc ? v13 : (v13 + 64'd1) >> 1;
      end else begin
        r14 <= (c[13].trunc || c[13].lz == 6'd0) ? xs13 : (xs13 + 64'd1) >> 1;
      end

      // Stage 15: special cases and sign.
      priority if (!c[14].comp) begin
        m_tdata <= 64'd0;
      end else if (c[14].bypass) begin
        m_tdata <= c[14].xin;
      end else if (c[14].zero) begin
        m_tdata <= 64'd0;
      end else begin
        m_tdata <= c[14].neg ? 64'd0 - r14 : r14;
      end
    end
  end

endmodule
`default_nettype wire
